>>> rtl/psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_pkg
// Shared constants and types for the prime sieve counter: map geometry,
// field widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package psc_pkg;

    // Largest number the candidate map can hold.
    localparam int MAX_LIMIT = 65535;

    // Map geometry and the widths that follow from it.
    localparam int MAP_DEPTH = MAX_LIMIT + 1;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int N_W       = ADDR_W + 1;
    localparam int P_W       = (ADDR_W + 1) / 2 + 1;
    localparam int PP_W      = 2 * P_W;

    // Fixed widths of the item fields.
    localparam int LIM_W = 16;
    localparam int CNT_W = 13;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_P_CHECK,
        ST_P_TEST,
        ST_CLEAR,
        ST_COUNT,
        ST_DONE
    } psc_state_t;

    // Number register operations.
    typedef enum logic [2:0] {
        N_HOLD,
        N_INC,
        N_ADD_P,
        N_LOAD_PP,
        N_LOAD_TWO
    } n_op_t;

    // Base register operations.
    typedef enum logic [1:0] {
        P_HOLD,
        P_LOAD_TWO,
        P_INC
    } p_op_t;

    // Map address source.
    typedef enum logic {
        ADDR_N,
        ADDR_P
    } addr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      ram_we;
        logic      ram_wdata;
        addr_sel_t addr_sel;
        n_op_t     n_op;
        p_op_t     p_op;
        logic      count_read;
    } psc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_le_lim;
        logic pp_le_lim;
        logic map_bit;
    } psc_status_t;

endpackage
`default_nettype wire

>>> rtl/psc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_ram
// Generic single-port RAM with one write or read address per cycle and a
// registered read port. Contents are not reset.
// ----------------------------------------------------------------------------
module psc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read of the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/psc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_datapath
// Limit, number, base and count registers for the sieve, plus the candidate
// map RAM. Executes the controller's commands and reports comparisons.
// ----------------------------------------------------------------------------
module psc_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [psc_pkg::LIM_W-1:0]       upper_limit,
    input  wire psc_pkg::psc_cmd_t               cmd,
    output psc_pkg::psc_status_t                 status,
    output logic      [psc_pkg::CNT_W-1:0]       prime_count
);

    import psc_pkg::*;

    logic [LIM_W-1:0]  lim_reg, lim_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [P_W-1:0]    p_reg, p_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pending_reg, pending_next;
    logic [LIM_W-1:0]  lim_sat;
    logic [PP_W-1:0]   pp;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_rdata;

    // Saturate the requested limit to the map size.
    always_comb
    begin
        if (32'(upper_limit) > 32'(MAX_LIMIT))
        begin
            lim_sat = LIM_W'(MAX_LIMIT);
        end
        else
        begin
            lim_sat = upper_limit;
        end
    end

    // Square of the current base.
    assign pp = PP_W'(p_reg) * PP_W'(p_reg);

    // Status comparisons for the controller.
    always_comb
    begin
        status.n_le_lim  = (32'(n_reg) <= 32'(lim_reg));
        status.pp_le_lim = (32'(pp) <= 32'(lim_reg));
        status.map_bit   = ram_rdata;
    end

    // Next values of the working registers.
    always_comb
    begin
        lim_next     = lim_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        count_next   = count_reg;
        pending_next = cmd.count_read;

        // A read issued by the count pass returns in the next cycle.
        if (pending_reg && ram_rdata)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        case (cmd.n_op)
            N_HOLD:     n_next = n_reg;
            N_INC:      n_next = n_reg + N_W'(1);
            N_ADD_P:    n_next = n_reg + N_W'(p_reg);
            N_LOAD_PP:  n_next = N_W'(pp);
            N_LOAD_TWO: n_next = N_W'(2);
            default:    n_next = n_reg;
        endcase

        case (cmd.p_op)
            P_HOLD:     p_next = p_reg;
            P_LOAD_TWO: p_next = P_W'(2);
            P_INC:      p_next = p_reg + P_W'(1);
            default:    p_next = p_reg;
        endcase

        // A new run starts from zero.
        if (cmd.load)
        begin
            lim_next   = lim_sat;
            n_next     = '0;
            count_next = '0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lim_reg   <= lim_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        count_reg <= count_next;
    end

    // Read-pending flag of the count pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Map address select.
    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_N:  ram_addr = ADDR_W'(n_reg);
            ADDR_P:  ram_addr = ADDR_W'(p_reg);
            default: ram_addr = ADDR_W'(n_reg);
        endcase
    end

    // Candidate map, one bit per number.
    psc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (cmd.ram_wdata),
        .rdata (ram_rdata)
    );

    assign prime_count = count_reg;

endmodule
`default_nettype wire

>>> rtl/psc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer for one sieve run: fill the map, strike out multiples of each
// surviving base, count the survivors and strobe the result.
// ----------------------------------------------------------------------------
module psc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire psc_pkg::psc_status_t status,
    output psc_pkg::psc_cmd_t         cmd,
    output logic                      busy,
    output logic                      done
);

    import psc_pkg::*;

    psc_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (!status.n_le_lim)
                begin
                    state_next = ST_P_CHECK;
                end
            end
            ST_P_CHECK:
            begin
                if (status.pp_le_lim)
                begin
                    state_next = ST_P_TEST;
                end
                else
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_P_TEST:
            begin
                if (status.map_bit)
                begin
                    state_next = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_P_CHECK;
                end
            end
            ST_CLEAR:
            begin
                if (!status.n_le_lim)
                begin
                    state_next = ST_P_CHECK;
                end
            end
            ST_COUNT:
            begin
                if (!status.n_le_lim)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and command logic.
    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.ram_we     = 1'b0;
        cmd.ram_wdata  = 1'b0;
        cmd.addr_sel   = ADDR_N;
        cmd.n_op       = N_HOLD;
        cmd.p_op       = P_HOLD;
        cmd.count_read = 1'b0;
        busy           = 1'b1;
        done           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_INIT:
            begin
                // Mark every number up to the limit as a candidate.
                if (status.n_le_lim)
                begin
                    cmd.ram_we    = 1'b1;
                    cmd.ram_wdata = 1'b1;
                    cmd.n_op      = N_INC;
                end
                else
                begin
                    cmd.p_op = P_LOAD_TWO;
                end
            end
            ST_P_CHECK:
            begin
                // Read the base's map bit, or move on to counting.
                if (status.pp_le_lim)
                begin
                    cmd.addr_sel = ADDR_P;
                end
                else
                begin
                    cmd.n_op = N_LOAD_TWO;
                end
            end
            ST_P_TEST:
            begin
                if (status.map_bit)
                begin
                    cmd.n_op = N_LOAD_PP;
                end
                else
                begin
                    cmd.p_op = P_INC;
                end
            end
            ST_CLEAR:
            begin
                // Strike out multiples of the base from its square.
                if (status.n_le_lim)
                begin
                    cmd.ram_we = 1'b1;
                    cmd.n_op   = N_ADD_P;
                end
                else
                begin
                    cmd.p_op = P_INC;
                end
            end
            ST_COUNT:
            begin
                if (status.n_le_lim)
                begin
                    cmd.count_read = 1'b1;
                    cmd.n_op       = N_INC;
                end
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/prime_sieve_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_sieve_counter
// Counts the primes up to a requested limit with a sieve over a one-bit
// candidate map held in a single-port RAM.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low; busy then stays high
// until the result has been shown. The result appears on prime_count for
// exactly one cycle with done high, and the receiver cannot hold it off, so
// it must capture prime_count in that cycle. A run makes one map access per
// cycle: it fills the map, reads the map bit of each base up to the square
// root of L, clears the multiples of each surviving base from its square
// and counts the survivors, where L is the limit. The single port of the map
// RAM is what bounds the run time.
// ----------------------------------------------------------------------------
module prime_sieve_counter (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [psc_pkg::LIM_W-1:0] upper_limit,
    output logic                           done,
    output logic      [psc_pkg::CNT_W-1:0] prime_count
);

    import psc_pkg::*;

    psc_cmd_t    cmd;
    psc_status_t status;

    // Sequencer.
    psc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Registers and candidate map.
    psc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .upper_limit (upper_limit),
        .cmd         (cmd),
        .status      (status),
        .prime_count (prime_count)
    );

endmodule
`default_nettype wire

>>> rtl/psc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks on the run handshake and the result strobe of the prime
// sieve counter, bound to the top level.
// ----------------------------------------------------------------------------
module psc_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic [psc_pkg::LIM_W-1:0] upper_limit,
    input wire logic                      done,
    input wire logic [psc_pkg::CNT_W-1:0] prime_count
);

    import psc_pkg::*;

    // An accepted item carries a fully known limit.
    a_limit_known: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> !$isunknown(upper_limit))
        else $error("unknown limit on an accepted item");

    // An accepted item makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // A result is only shown while a run is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a run");

    // The result strobe lasts one cycle and frees the block.
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe longer than one cycle");

    // The count stays within the primes that fit a 16-bit limit.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (prime_count <= CNT_W'(6542)))
        else $error("prime count out of range");

endmodule

bind prime_sieve_counter psc_checker u_psc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .upper_limit (upper_limit),
    .done        (done),
    .prime_count (prime_count)
);
`default_nettype wire
